// File: hw/rtl/bvfs_pkg.sv
// shared constants, codes and helpers of the bilinear vector field sampler
`default_nettype none

package bvfs_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_FRAMES  = 4;
    localparam int DEF_FRAC_BITS   = 8;

    localparam int CFG_W       = 7;
    localparam int POS_W       = 14;
    localparam int LOAD_IDX_W  = 14;
    localparam int SAMPLE_W    = 16;
    localparam int FRAME_W     = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(64);

    typedef enum logic
    {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } reg_idx_t;

    typedef enum logic
    {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    // width of one queue entry: kind, address, columns, two fractions, sample pair
    function automatic int entry_width(input int aw, input int cw, input int fw);
        return 1 + aw + cw + 2 * fw + 2 * SAMPLE_W;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bvfs_if.sv
// item and result channel interfaces
`default_nettype none

interface bvfs_in_if import bvfs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [LOAD_IDX_W-1:0]      load_index;
    logic signed [SAMPLE_W-1:0] sample_u;
    logic signed [SAMPLE_W-1:0] sample_v;
    logic [FRAME_W-1:0]         frame_sel;
    logic [POS_W-1:0]           x_pos;
    logic [POS_W-1:0]           y_pos;

    modport source
    (
        output valid, mode, load_index, sample_u, sample_v, frame_sel, x_pos, y_pos,
        input  ready
    );
    modport sink
    (
        input  valid, mode, load_index, sample_u, sample_v, frame_sel, x_pos, y_pos,
        output ready
    );
endinterface

interface bvfs_out_if import bvfs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] vel_u;
    logic signed [SAMPLE_W-1:0] vel_v;

    modport source
    (
        output valid, vel_u, vel_v,
        input  ready
    );
    modport sink
    (
        input  valid, vel_u, vel_v,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/bilinear_vector_field_sampler.sv
// bilinear vector field sampler: top level with configuration registers
//
// items channel: mode 0 loads one {u, v} sample pair at load_index, mode 1
// queries frame_sel at (x_pos, y_pos) with FRAC_BITS fraction bits.
// results channel: one {vel_u, vel_v} per query, in query order; loads give none.
// apb port: grid_columns at byte 0, grid_rows at byte 4, both reset to 64.
// a query passes three address stages, the queue, the store read and the x
// and y lerp stages before its result shows.
// throughput: one item per cycle while items.ready is high; each store copy
// serves two neighbour reads a cycle, a top-row copy and a bottom-row copy,
// so all four arrive at once. when the receiver stalls, the result holds and
// the back end freezes; the four-entry queue and the front stages keep taking
// items until the queue fills, then items.ready drops and comes back in the
// cycle after the stall ends. reset clears the pipelines and queue and sets
// the grid to 64 by 64; store contents stay undefined until loaded.
`default_nettype none

module bilinear_vector_field_sampler import bvfs_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bvfs_in_if.sink                    items,
    bvfs_out_if.source                 results,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS * MAX_FRAMES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int FW    = FRAC_BITS + 1;
    localparam int ENT_W = entry_width(AW, CW, FW);

    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    reg_idx_t         reg_idx;
    logic             cfg_write;

    logic             q_wr_valid;
    logic [ENT_W-1:0] q_wr_data;
    logic             q_full;
    logic             q_rd_valid;
    logic             q_rd_ready;
    logic [ENT_W-1:0] q_rd_data;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_COLS: cols_reg <= pwdata[CFG_W-1:0];
                REG_ROWS: rows_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COLS: prdata = APB_DATA_W'(cols_reg);
            REG_ROWS: prdata = APB_DATA_W'(rows_reg);
        endcase
    end

    bvfs_front
    #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_FRAMES  (MAX_FRAMES),
        .FRAC_BITS   (FRAC_BITS),
        .ENT_W       (ENT_W)
    )
    u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg_cols (cols_reg),
        .cfg_rows (rows_reg),
        .q_valid  (q_wr_valid),
        .q_full   (q_full),
        .q_data   (q_wr_data)
    );

    bvfs_fifo
    #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    bvfs_back
    #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_FRAMES  (MAX_FRAMES),
        .FRAC_BITS   (FRAC_BITS),
        .ENT_W       (ENT_W)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_rd_valid),
        .q_ready (q_rd_ready),
        .q_data  (q_rd_data),
        .results (results)
    );

endmodule

`default_nettype wire

// File: hw/rtl/bvfs_front.sv
// front end: accepts items, clamps positions and computes store addresses
`default_nettype none

module bvfs_front import bvfs_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int ENT_W       = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    bvfs_in_if.sink               items,
    input  wire logic [CFG_W-1:0] cfg_cols,
    input  wire logic [CFG_W-1:0] cfg_rows,
    output logic                  q_valid,
    input  wire logic             q_full,
    output logic [ENT_W-1:0]      q_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS * MAX_FRAMES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int FW    = FRAC_BITS + 1;
    localparam int IW    = POS_W - FRAC_BITS;

    typedef struct packed
    {
        logic                is_query;
        logic [AW-1:0]       addr;
        logic [CW-1:0]       cols;
        logic [FW-1:0]       fx;
        logic [FW-1:0]       fy;
        logic [SAMPLE_W-1:0] su;
        logic [SAMPLE_W-1:0] sv;
    } entry_t;

    logic               en;
    logic               accept;
    logic [CW-1:0]      cols_next;
    logic [RW-1:0]      rows_next;
    logic [FRAME_W-1:0] frame_next;
    logic [IW-1:0]      xi;
    logic [IW-1:0]      yi;
    logic [CW-1:0]      ix_next;
    logic [RW-1:0]      iy_next;
    logic [FW-1:0]      fx_next;
    logic [FW-1:0]      fy_next;
    logic               load_ok;
    logic               is_query;

    logic                s1_valid_reg;
    logic                s1_query_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [FRAME_W-1:0]  s1_frame_reg;
    logic [RW-1:0]       s1_rows_reg;
    logic [CW-1:0]       s1_cols_reg;
    logic [CW-1:0]       s1_ix_reg;
    logic [RW-1:0]       s1_iy_reg;
    logic [FW-1:0]       s1_fx_reg;
    logic [FW-1:0]       s1_fy_reg;
    logic [SAMPLE_W-1:0] s1_su_reg;
    logic [SAMPLE_W-1:0] s1_sv_reg;

    logic                s2_valid_reg;
    logic                s2_query_reg;
    logic [AW-1:0]       s2_addr_reg;
    logic [CW-1:0]       s2_cols_reg;
    logic [CW-1:0]       s2_ix_reg;
    logic [FW-1:0]       s2_fx_reg;
    logic [FW-1:0]       s2_fy_reg;
    logic [SAMPLE_W-1:0] s2_su_reg;
    logic [SAMPLE_W-1:0] s2_sv_reg;

    logic                s3_valid_reg;
    entry_t              s3_ent_reg;

    assign en           = !(s3_valid_reg && q_full);
    assign items.ready  = en;
    assign accept       = items.valid && en;
    assign is_query     = (items.mode == MODE_QUERY);
    assign load_ok      = (int'(items.load_index) < DEPTH);
    assign xi           = items.x_pos[POS_W-1:FRAC_BITS];
    assign yi           = items.y_pos[POS_W-1:FRAC_BITS];

    always_comb
    begin
        if (cfg_cols < CFG_W'(2))
        begin
            cols_next = CW'(2);
        end
        else if (int'(cfg_cols) > MAX_COLUMNS)
        begin
            cols_next = CW'(MAX_COLUMNS);
        end
        else
        begin
            cols_next = CW'(cfg_cols);
        end

        if (cfg_rows < CFG_W'(2))
        begin
            rows_next = RW'(2);
        end
        else if (int'(cfg_rows) > MAX_ROWS)
        begin
            rows_next = RW'(MAX_ROWS);
        end
        else
        begin
            rows_next = RW'(cfg_rows);
        end

        if (int'(items.frame_sel) >= MAX_FRAMES)
        begin
            frame_next = FRAME_W'(MAX_FRAMES - 1);
        end
        else
        begin
            frame_next = items.frame_sel;
        end

        // at or past the last grid line: sit on the last cell with a full fraction
        if (int'(xi) >= int'(cols_next) - 1)
        begin
            ix_next = CW'(int'(cols_next) - 2);
            fx_next = FW'(1 << FRAC_BITS);
        end
        else
        begin
            ix_next = CW'(xi);
            fx_next = {1'b0, items.x_pos[FRAC_BITS-1:0]};
        end

        if (int'(yi) >= int'(rows_next) - 1)
        begin
            iy_next = RW'(int'(rows_next) - 2);
            fy_next = FW'(1 << FRAC_BITS);
        end
        else
        begin
            iy_next = RW'(yi);
            fy_next = {1'b0, items.y_pos[FRAC_BITS-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            // loads beyond the store are dropped here
            s1_valid_reg <= accept && (is_query || load_ok);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_query_reg <= is_query;
            s1_addr_reg  <= AW'(items.load_index);
            s1_frame_reg <= frame_next;
            s1_rows_reg  <= rows_next;
            s1_cols_reg  <= cols_next;
            s1_ix_reg    <= ix_next;
            s1_iy_reg    <= iy_next;
            s1_fx_reg    <= fx_next;
            s1_fy_reg    <= fy_next;
            s1_su_reg    <= items.sample_u;
            s1_sv_reg    <= items.sample_v;

            s2_query_reg <= s1_query_reg;
            if (s1_query_reg)
            begin
                s2_addr_reg <= AW'(AW'(s1_frame_reg) * AW'(s1_rows_reg)) + AW'(s1_iy_reg);
            end
            else
            begin
                s2_addr_reg <= s1_addr_reg;
            end
            s2_cols_reg  <= s1_cols_reg;
            s2_ix_reg    <= s1_ix_reg;
            s2_fx_reg    <= s1_fx_reg;
            s2_fy_reg    <= s1_fy_reg;
            s2_su_reg    <= s1_su_reg;
            s2_sv_reg    <= s1_sv_reg;

            s3_ent_reg.is_query <= s2_query_reg;
            if (s2_query_reg)
            begin
                s3_ent_reg.addr <= AW'(s2_addr_reg * AW'(s2_cols_reg)) + AW'(s2_ix_reg);
            end
            else
            begin
                s3_ent_reg.addr <= s2_addr_reg;
            end
            s3_ent_reg.cols <= s2_cols_reg;
            s3_ent_reg.fx   <= s2_fx_reg;
            s3_ent_reg.fy   <= s2_fy_reg;
            s3_ent_reg.su   <= s2_su_reg;
            s3_ent_reg.sv   <= s2_sv_reg;
        end
    end

    assign q_valid = s3_valid_reg;
    assign q_data  = ENT_W'(s3_ent_reg);

endmodule

`default_nettype wire

// File: hw/rtl/bvfs_fifo.sv
// short queue between front end and back end
`default_nettype none

module bvfs_fifo import bvfs_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign full     = (count_reg == NW'(DEPTH));
    assign rd_valid = (count_reg != NW'(0));
    assign push     = wr_valid && !full;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bvfs_back.sv
// back end: sample stores, neighbour reads and the two interpolation stages
`default_nettype none

module bvfs_back import bvfs_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int ENT_W       = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire logic [ENT_W-1:0] q_data,
    bvfs_out_if.source            results
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS * MAX_FRAMES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int FW    = FRAC_BITS + 1;
    localparam int PRW   = SAMPLE_W + FW + 2;
    localparam int WW    = 2 * SAMPLE_W;

    typedef struct packed
    {
        logic                is_query;
        logic [AW-1:0]       addr;
        logic [CW-1:0]       cols;
        logic [FW-1:0]       fx;
        logic [FW-1:0]       fy;
        logic [SAMPLE_W-1:0] su;
        logic [SAMPLE_W-1:0] sv;
    } entry_t;

    // a + floor((b - a) * f / 2^FRAC_BITS)
    function automatic logic signed [SAMPLE_W-1:0] lerp
    (
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [FW-1:0]              f
    );
        logic signed [SAMPLE_W:0] d;
        logic signed [PRW-1:0]    p;
        logic signed [PRW-1:0]    q;
        d = (SAMPLE_W + 1)'(b) - (SAMPLE_W + 1)'(a);
        p = PRW'(d) * PRW'($signed({1'b0, f}));
        q = p >>> FRAC_BITS;
        return SAMPLE_W'(q + PRW'(a));
    endfunction

    // two copies of the {u, v} store, each with two read ports
    logic [WW-1:0] mem_top [DEPTH];
    logic [WW-1:0] mem_bot [DEPTH];

    entry_t        ent;
    logic          en;
    logic          pop;
    logic          wr;
    logic          rd;
    logic [AW-1:0] a01;
    logic [AW-1:0] a10;
    logic [AW-1:0] a11;

    logic          b1_valid_reg;
    logic [WW-1:0] r00_reg;
    logic [WW-1:0] r01_reg;
    logic [WW-1:0] r10_reg;
    logic [WW-1:0] r11_reg;
    logic [FW-1:0] b1_fx_reg;
    logic [FW-1:0] b1_fy_reg;

    logic                       b2_valid_reg;
    logic signed [SAMPLE_W-1:0] top_u_reg;
    logic signed [SAMPLE_W-1:0] bot_u_reg;
    logic signed [SAMPLE_W-1:0] top_v_reg;
    logic signed [SAMPLE_W-1:0] bot_v_reg;
    logic [FW-1:0]              b2_fy_reg;

    logic                       o_valid_reg;
    logic signed [SAMPLE_W-1:0] o_u_reg;
    logic signed [SAMPLE_W-1:0] o_v_reg;

    assign ent     = entry_t'(q_data);
    assign en      = !(o_valid_reg && !results.ready);
    assign q_ready = en;
    assign pop     = q_valid && en;
    assign wr      = pop && !ent.is_query;
    assign rd      = pop && ent.is_query;
    assign a01     = ent.addr + AW'(1);
    assign a10     = ent.addr + AW'(ent.cols);
    assign a11     = a10 + AW'(1);

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_top[ent.addr] <= {ent.su, ent.sv};
        end
        if (rd)
        begin
            r00_reg <= mem_top[ent.addr];
            r01_reg <= mem_top[a01];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_bot[ent.addr] <= {ent.su, ent.sv};
        end
        if (rd)
        begin
            r10_reg <= mem_bot[a10];
            r11_reg <= mem_bot[a11];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= rd;
            b2_valid_reg <= b1_valid_reg;
            o_valid_reg  <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            b1_fx_reg <= ent.fx;
            b1_fy_reg <= ent.fy;
        end
        if (en && b1_valid_reg)
        begin
            top_u_reg <= lerp(r00_reg[WW-1:SAMPLE_W], r01_reg[WW-1:SAMPLE_W], b1_fx_reg);
            bot_u_reg <= lerp(r10_reg[WW-1:SAMPLE_W], r11_reg[WW-1:SAMPLE_W], b1_fx_reg);
            top_v_reg <= lerp(r00_reg[SAMPLE_W-1:0], r01_reg[SAMPLE_W-1:0], b1_fx_reg);
            bot_v_reg <= lerp(r10_reg[SAMPLE_W-1:0], r11_reg[SAMPLE_W-1:0], b1_fx_reg);
            b2_fy_reg <= b1_fy_reg;
        end
        if (en && b2_valid_reg)
        begin
            o_u_reg <= lerp(top_u_reg, bot_u_reg, b2_fy_reg);
            o_v_reg <= lerp(top_v_reg, bot_v_reg, b2_fy_reg);
        end
    end

    assign results.valid = o_valid_reg;
    assign results.vel_u = o_u_reg;
    assign results.vel_v = o_v_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bvfs_checker.sv
// port-level assertions for the sampler and their bind
`default_nettype none

module bvfs_checker import bvfs_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [SAMPLE_W-1:0]   vel_u,
    input wire logic [SAMPLE_W-1:0]   vel_v,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [APB_DATA_W-1:0] pwdata,
    input wire logic [APB_DATA_W-1:0] prdata,
    input wire logic                  pready
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vel_u) && $stable(vel_v))
        else $error("result changed while stalled");

    // a written register reads back as its low bits
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=>
        (paddr[2] != $past(paddr[2]))
        || (prdata == APB_DATA_W'($past(pwdata[CFG_W-1:0]))))
        else $error("register readback mismatch");

    // once the result slot stays empty, the queue drains enough to take items again
    a_ready_recovers: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 !out_valid |-> in_ready)
        else $error("items not accepted although results side is free");

endmodule

bind bilinear_vector_field_sampler bvfs_checker u_bvfs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .vel_u     (results.vel_u),
    .vel_v     (results.vel_v),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire
